// File: hw/rtl/chac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chac_pkg;

  localparam int SAMPLE_BITS = 16;

  // re-centered sample and the scaled vector magnitudes
  localparam int XC_W      = SAMPLE_BITS + 2;
  localparam int MAG_W     = 2 * SAMPLE_BITS + 1;
  localparam int NORM_BITS = 33;
  localparam int NW        = (MAG_W < NORM_BITS) ? MAG_W : NORM_BITS;
  localparam int HALF_W    = (NW + 1) / 2;

  // shared multiplier: constant-ish operand times a half word or a span
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = (HALF_W > SAMPLE_BITS) ? HALF_W : SAMPLE_BITS;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = MUL_A_W + 2 * HALF_W;

  localparam logic [63:0]        NORM_LIMIT = 64'd8589934592;
  localparam logic [MUL_A_W-1:0] TAN_SCALE  = 30'd1000000000;

  localparam int          K_W      = 6;
  localparam logic [K_W-1:0] K_LAST = 6'd44;
  localparam logic [K_W-1:0] K_DIAG = 6'd45;

  localparam int          DEG_W       = 9;
  localparam logic [8:0]  FULL_TURN   = 9'd360;
  localparam logic [7:0]  HALF_TURN   = 8'd180;
  localparam logic [7:0]  HALF_TURN_M = 8'd179;
  localparam logic [6:0]  QUARTER     = 7'd90;
  localparam logic [6:0]  QUARTER_M   = 7'd89;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOUND,
    ST_CENTER,
    ST_MULX,
    ST_MULY,
    ST_PREP,
    ST_NORM,
    ST_PHI,
    ST_PLO,
    ST_KHI,
    ST_KLO,
    ST_KCMP,
    ST_FINAL,
    ST_OUT
  } chac_state_t;

  // tan(k deg) scaled by 10^9, rounded
  function automatic logic [MUL_A_W-1:0] tan_deg(input logic [K_W-1:0] k);
    logic [MUL_A_W-1:0] t;
    case (k)
      6'd0:  t = 30'd0;
      6'd1:  t = 30'd17455065;
      6'd2:  t = 30'd34920769;
      6'd3:  t = 30'd52407779;
      6'd4:  t = 30'd69926812;
      6'd5:  t = 30'd87488664;
      6'd6:  t = 30'd105104235;
      6'd7:  t = 30'd122784561;
      6'd8:  t = 30'd140540835;
      6'd9:  t = 30'd158384440;
      6'd10: t = 30'd176326981;
      6'd11: t = 30'd194380309;
      6'd12: t = 30'd212556562;
      6'd13: t = 30'd230868191;
      6'd14: t = 30'd249328003;
      6'd15: t = 30'd267949192;
      6'd16: t = 30'd286745386;
      6'd17: t = 30'd305730681;
      6'd18: t = 30'd324919696;
      6'd19: t = 30'd344327613;
      6'd20: t = 30'd363970234;
      6'd21: t = 30'd383864035;
      6'd22: t = 30'd404026226;
      6'd23: t = 30'd424474816;
      6'd24: t = 30'd445228685;
      6'd25: t = 30'd466307658;
      6'd26: t = 30'd487732589;
      6'd27: t = 30'd509525449;
      6'd28: t = 30'd531709432;
      6'd29: t = 30'd554309051;
      6'd30: t = 30'd577350269;
      6'd31: t = 30'd600860619;
      6'd32: t = 30'd624869352;
      6'd33: t = 30'd649407593;
      6'd34: t = 30'd674508517;
      6'd35: t = 30'd700207538;
      6'd36: t = 30'd726542528;
      6'd37: t = 30'd753554050;
      6'd38: t = 30'd781285627;
      6'd39: t = 30'd809784033;
      6'd40: t = 30'd839099631;
      6'd41: t = 30'd869286738;
      6'd42: t = 30'd900404044;
      6'd43: t = 30'd932515086;
      6'd44: t = 30'd965688775;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/chac_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface chac_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic signed [chac_pkg::SAMPLE_BITS-1:0] mag_x;
  logic signed [chac_pkg::SAMPLE_BITS-1:0] mag_y;

  modport source (output valid, output opcode, output mag_x, output mag_y, input ready);
  modport sink   (input valid, input opcode, input mag_x, input mag_y, output ready);
endinterface

interface chac_out_if;
  logic                          valid;
  logic                          ready;
  logic [chac_pkg::DEG_W-1:0]    heading_deg;
  logic                          heading_valid;

  modport source (output valid, output heading_deg, output heading_valid, input ready);
  modport sink   (input valid, input heading_deg, input heading_valid, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/compass_heading_autocal.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    dir  payload                         handshake
// in_chan    in   opcode, mag_x, mag_y            valid / ready
// out_chan   out  heading_deg, heading_valid      valid / ready
//
// a sample request runs a binary search over the tan table, skipped when the octant
// ratio is zero or one; a zero span or a clear skips the products and the search;
// one 30 x 17 multiplier does every product
// reset (rst_n low, synchronous) zeroes the calibration bounds and the sequencer
// in_chan.ready is high only while the sequencer is idle; a finished result waits in
// the output register and the next request may be taken meanwhile; the sequencer
// holds in its last step while that register is still full
module compass_heading_autocal (
  input  wire logic      clk,
  input  wire logic      rst_n,
  chac_in_if.sink        in_chan,
  chac_out_if.source     out_chan
);

  localparam int SB = chac_pkg::SAMPLE_BITS;

  chac_pkg::chac_state_t state_r, state_nxt;

  logic                 op_r, op_nxt;
  logic signed [SB-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [SB-1:0] xmin_r, xmin_nxt, xmax_r, xmax_nxt;
  logic signed [SB-1:0] ymin_r, ymin_nxt, ymax_r, ymax_nxt;

  logic signed [chac_pkg::XC_W-1:0] xc_r, xc_nxt, yc_r, yc_nxt;
  logic [SB-1:0]                    sx_r, sx_nxt, sy_r, sy_nxt;
  logic                             xneg_r, xneg_nxt, yneg_r, yneg_nxt;

  logic [chac_pkg::MAG_W-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [chac_pkg::MAG_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic                       steep_r, steep_nxt, ex_r, ex_nxt;

  logic [chac_pkg::ACC_W-1:0] acc_r, acc_nxt, p_r, p_nxt;
  logic [chac_pkg::K_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;

  logic [chac_pkg::DEG_W-1:0] res_deg_r, res_deg_nxt;
  logic                       res_val_r, res_val_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [chac_pkg::DEG_W-1:0] out_deg_r, out_deg_nxt;
  logic                       out_hv_r, out_hv_nxt;

  // shared multiplier
  logic [chac_pkg::MUL_A_W-1:0] mul_a;
  logic [chac_pkg::MUL_B_W-1:0] mul_b;
  logic [chac_pkg::PROD_W-1:0]  prod;

  // centering
  logic signed [SB:0]               sumx, sumy, sumx_adj, sumy_adj, midx, midy;
  logic signed [SB:0]               spx, spy;
  logic signed [chac_pkg::XC_W-1:0] xc_calc, yc_calc;
  logic [chac_pkg::XC_W-1:0]        xabs, yabs;

  // halves of the normalized magnitudes
  logic [2*chac_pkg::HALF_W-1:0] a_pad, b_pad;
  logic [chac_pkg::K_W:0]        ksum;
  logic [chac_pkg::K_W-1:0]      k_mid;
  logic                          norm_big, k_pass;

  // final reflection
  logic [6:0] pf;
  logic [7:0] mf;
  logic [8:0] hdg;

  assign sumx     = (SB+1)'(xmax_r) + (SB+1)'(xmin_r);
  assign sumy     = (SB+1)'(ymax_r) + (SB+1)'(ymin_r);
  // halve toward zero: a negative sum gets one added before the arithmetic shift
  assign sumx_adj = sumx + $signed({{SB{1'b0}}, sumx[SB]});
  assign sumy_adj = sumy + $signed({{SB{1'b0}}, sumy[SB]});
  assign midx     = {sumx_adj[SB], sumx_adj[SB:1]};
  assign midy     = {sumy_adj[SB], sumy_adj[SB:1]};
  assign spx      = (SB+1)'(xmax_r) - (SB+1)'(xmin_r);
  assign spy      = (SB+1)'(ymax_r) - (SB+1)'(ymin_r);
  assign xc_calc  = chac_pkg::XC_W'(x_r) - chac_pkg::XC_W'(midx);
  assign yc_calc  = chac_pkg::XC_W'(y_r) - chac_pkg::XC_W'(midy);
  assign xabs     = xneg_r ? chac_pkg::XC_W'(-xc_r) : chac_pkg::XC_W'(xc_r);
  assign yabs     = yneg_r ? chac_pkg::XC_W'(-yc_r) : chac_pkg::XC_W'(yc_r);

  assign a_pad    = (2*chac_pkg::HALF_W)'(a_r[chac_pkg::NW-1:0]);
  assign b_pad    = (2*chac_pkg::HALF_W)'(b_r[chac_pkg::NW-1:0]);
  assign ksum     = {1'b0, lo_r} + {1'b0, hi_r} + (chac_pkg::K_W+1)'(1);
  assign k_mid    = ksum[chac_pkg::K_W:1];
  assign norm_big = (64'(b_r) >= chac_pkg::NORM_LIMIT);
  assign k_pass   = (acc_r <= p_r);

  assign prod     = chac_pkg::PROD_W'(mul_a) * chac_pkg::PROD_W'(mul_b);

  always_comb begin
    pf  = steep_r ? (ex_r ? chac_pkg::QUARTER - {1'b0, lo_r}
                          : chac_pkg::QUARTER_M - {1'b0, lo_r})
                  : {1'b0, lo_r};
    mf  = xneg_r ? (ex_r ? chac_pkg::HALF_TURN - {1'b0, pf}
                         : chac_pkg::HALF_TURN_M - {1'b0, pf})
                 : {1'b0, pf};
    if (yneg_r) begin
      hdg = chac_pkg::FULL_TURN - {1'b0, mf};
    end else if (mf == 8'd0) begin
      hdg = chac_pkg::FULL_TURN;
    end else begin
      hdg = {1'b0, mf};
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      chac_pkg::ST_MULX: begin
        mul_a = chac_pkg::MUL_A_W'(xabs);
        mul_b = chac_pkg::MUL_B_W'(sy_r);
      end
      chac_pkg::ST_MULY: begin
        mul_a = chac_pkg::MUL_A_W'(yabs);
        mul_b = chac_pkg::MUL_B_W'(sx_r);
      end
      chac_pkg::ST_PHI: begin
        mul_a = chac_pkg::TAN_SCALE;
        mul_b = chac_pkg::MUL_B_W'(a_pad[2*chac_pkg::HALF_W-1:chac_pkg::HALF_W]);
      end
      chac_pkg::ST_PLO: begin
        mul_a = chac_pkg::TAN_SCALE;
        mul_b = chac_pkg::MUL_B_W'(a_pad[chac_pkg::HALF_W-1:0]);
      end
      chac_pkg::ST_KHI: begin
        mul_a = chac_pkg::tan_deg(k_mid);
        mul_b = chac_pkg::MUL_B_W'(b_pad[2*chac_pkg::HALF_W-1:chac_pkg::HALF_W]);
      end
      chac_pkg::ST_KLO: begin
        mul_a = chac_pkg::tan_deg(k_mid);
        mul_b = chac_pkg::MUL_B_W'(b_pad[chac_pkg::HALF_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    xmin_nxt      = xmin_r;
    xmax_nxt      = xmax_r;
    ymin_nxt      = ymin_r;
    ymax_nxt      = ymax_r;
    xc_nxt        = xc_r;
    yc_nxt        = yc_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    xneg_nxt      = xneg_r;
    yneg_nxt      = yneg_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    steep_nxt     = steep_r;
    ex_nxt        = ex_r;
    acc_nxt       = acc_r;
    p_nxt         = p_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_deg_nxt   = res_deg_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r;
    out_deg_nxt   = out_deg_r;
    out_hv_nxt    = out_hv_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      chac_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          op_nxt    = in_chan.opcode;
          x_nxt     = in_chan.mag_x;
          y_nxt     = in_chan.mag_y;
          state_nxt = chac_pkg::ST_BOUND;
        end
      end
      chac_pkg::ST_BOUND: begin
        res_deg_nxt = '0;
        res_val_nxt = 1'b0;
        if (op_r == chac_pkg::OP_CLEAR) begin
          xmin_nxt  = '0;
          xmax_nxt  = '0;
          ymin_nxt  = '0;
          ymax_nxt  = '0;
          state_nxt = chac_pkg::ST_OUT;
        end else begin
          if (x_r < xmin_r) xmin_nxt = x_r;
          if (x_r > xmax_r) xmax_nxt = x_r;
          if (y_r < ymin_r) ymin_nxt = y_r;
          if (y_r > ymax_r) ymax_nxt = y_r;
          state_nxt = chac_pkg::ST_CENTER;
        end
      end
      chac_pkg::ST_CENTER: begin
        xc_nxt   = xc_calc;
        yc_nxt   = yc_calc;
        xneg_nxt = xc_calc[chac_pkg::XC_W-1];
        yneg_nxt = yc_calc[chac_pkg::XC_W-1];
        sx_nxt   = spx[SB-1:0];
        sy_nxt   = spy[SB-1:0];
        if (spx == '0 || spy == '0) begin
          state_nxt = chac_pkg::ST_OUT;
        end else begin
          state_nxt = chac_pkg::ST_MULX;
        end
      end
      chac_pkg::ST_MULX: begin
        ax_nxt    = chac_pkg::MAG_W'(prod);
        state_nxt = chac_pkg::ST_MULY;
      end
      chac_pkg::ST_MULY: begin
        ay_nxt    = chac_pkg::MAG_W'(prod);
        state_nxt = chac_pkg::ST_PREP;
      end
      chac_pkg::ST_PREP: begin
        steep_nxt = (ax_r < ay_r);
        a_nxt     = (ax_r >= ay_r) ? ay_r : ax_r;
        b_nxt     = (ax_r >= ay_r) ? ax_r : ay_r;
        ex_nxt    = (ax_r == '0) || (ay_r == '0) || (ax_r == ay_r);
        hi_nxt    = chac_pkg::K_LAST;
        // zero ratio (also the zero vector) and the diagonal need no search
        if (ax_r == '0 || ay_r == '0) begin
          lo_nxt    = '0;
          state_nxt = chac_pkg::ST_FINAL;
        end else if (ax_r == ay_r) begin
          lo_nxt    = chac_pkg::K_DIAG;
          state_nxt = chac_pkg::ST_FINAL;
        end else begin
          lo_nxt    = '0;
          state_nxt = chac_pkg::ST_NORM;
        end
      end
      chac_pkg::ST_NORM: begin
        if (norm_big) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
        end else begin
          state_nxt = chac_pkg::ST_PHI;
        end
      end
      chac_pkg::ST_PHI: begin
        acc_nxt   = chac_pkg::ACC_W'(prod);
        state_nxt = chac_pkg::ST_PLO;
      end
      chac_pkg::ST_PLO: begin
        p_nxt     = (acc_r << chac_pkg::HALF_W) + chac_pkg::ACC_W'(prod);
        state_nxt = chac_pkg::ST_KHI;
      end
      chac_pkg::ST_KHI: begin
        acc_nxt   = chac_pkg::ACC_W'(prod);
        state_nxt = chac_pkg::ST_KLO;
      end
      chac_pkg::ST_KLO: begin
        acc_nxt   = (acc_r << chac_pkg::HALF_W) + chac_pkg::ACC_W'(prod);
        state_nxt = chac_pkg::ST_KCMP;
      end
      chac_pkg::ST_KCMP: begin
        // largest k with tan_k * b <= a * 10^9
        if (k_pass) begin
          lo_nxt = k_mid;
        end else begin
          hi_nxt = k_mid - chac_pkg::K_W'(1);
        end
        if ((k_pass && k_mid == hi_r) || (!k_pass && (k_mid - chac_pkg::K_W'(1)) == lo_r)) begin
          state_nxt = chac_pkg::ST_FINAL;
        end else begin
          state_nxt = chac_pkg::ST_KHI;
        end
      end
      chac_pkg::ST_FINAL: begin
        res_deg_nxt = hdg;
        res_val_nxt = 1'b1;
        state_nxt   = chac_pkg::ST_OUT;
      end
      chac_pkg::ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_deg_nxt   = res_deg_r;
          out_hv_nxt    = res_val_r;
          state_nxt     = chac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = chac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chac_pkg::ST_IDLE;
      xmin_r      <= '0;
      xmax_r      <= '0;
      ymin_r      <= '0;
      ymax_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      xmin_r      <= xmin_nxt;
      xmax_r      <= xmax_nxt;
      ymin_r      <= ymin_nxt;
      ymax_r      <= ymax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    xc_r      <= xc_nxt;
    yc_r      <= yc_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    xneg_r    <= xneg_nxt;
    yneg_r    <= yneg_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    steep_r   <= steep_nxt;
    ex_r      <= ex_nxt;
    acc_r     <= acc_nxt;
    p_r       <= p_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    res_deg_r <= res_deg_nxt;
    res_val_r <= res_val_nxt;
    out_deg_r <= out_deg_nxt;
    out_hv_r  <= out_hv_nxt;
  end

  assign in_chan.ready          = (state_r == chac_pkg::ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.heading_deg   = out_deg_r;
  assign out_chan.heading_valid = out_hv_r;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request taken while a previous one is in work");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.heading_valid |->
      out_chan.heading_deg != '0 && out_chan.heading_deg <= chac_pkg::FULL_TURN)
    else $error("valid heading out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.heading_valid |-> out_chan.heading_deg == '0)
    else $error("invalid heading is not zero");

  a_bounds_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
    xmin_r <= 0 && xmax_r >= 0 && ymin_r <= 0 && ymax_r >= 0)
    else $error("calibration span lost zero");

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == chac_pkg::ST_KCMP |-> lo_r < hi_r && hi_r <= chac_pkg::K_LAST)
    else $error("tan search bounds crossed");

endmodule

`default_nettype wire

// File: test/heading_checker.sv
`timescale 1ns / 1ps

module heading_checker (
  input  logic clk,
  input  logic rst_n,
  chac_in_if   in_mon,
  chac_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);

  localparam longint unsigned NANO_SCALE  = 64'd1000000000;
  localparam longint unsigned SHIFT_LIMIT = 64'd8589934592;

  typedef struct packed {
    logic [8:0] deg;
    logic       ok;
  } heading_t;

  // tan of each whole degree 0..44, times 10^9, rounded
  longint unsigned tan_nano [45] = '{
    64'd0, 64'd17455065, 64'd34920769, 64'd52407779, 64'd69926812,
    64'd87488664, 64'd105104235, 64'd122784561, 64'd140540835, 64'd158384440,
    64'd176326981, 64'd194380309, 64'd212556562, 64'd230868191, 64'd249328003,
    64'd267949192, 64'd286745386, 64'd305730681, 64'd324919696, 64'd344327613,
    64'd363970234, 64'd383864035, 64'd404026226, 64'd424474816, 64'd445228685,
    64'd466307658, 64'd487732589, 64'd509525449, 64'd531709432, 64'd554309051,
    64'd577350269, 64'd600860619, 64'd624869352, 64'd649407593, 64'd674508517,
    64'd700207538, 64'd726542528, 64'd753554050, 64'd781285627, 64'd809784033,
    64'd839099631, 64'd869286738, 64'd900404044, 64'd932515086, 64'd965688775
  };

  longint   x_lo, x_hi, y_lo, y_hi;
  heading_t heading_q [$];
  heading_t want;
  int       errs = 0;

  // whole degrees of atan2(vy, vx) truncated toward zero, folded into 1..360
  function automatic int angle_deg(longint vx, longint vy);
    longint unsigned ax, ay, lo, hi;
    int oct, pf, mf, k;
    bit exact;
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    lo = (ax >= ay) ? ay : ax;
    hi = (ax >= ay) ? ax : ay;
    oct = 0;
    if (hi == 0) return 360;
    exact = (lo == 0) || (lo == hi);
    if (lo == hi) begin
      oct = 45;
    end else if (lo != 0) begin
      while (hi >= SHIFT_LIMIT) begin
        lo = lo >> 1;
        hi = hi >> 1;
      end
      for (k = 1; k < 45; k++) begin
        if (tan_nano[k] * hi <= lo * NANO_SCALE) oct = k;
      end
    end
    if (ax >= ay) pf = oct;
    else pf = exact ? 90 - oct : 89 - oct;
    if (vx >= 0) mf = pf;
    else mf = exact ? 180 - pf : 179 - pf;
    if (vy < 0) return 360 - mf;
    return (mf == 0) ? 360 : mf;
  endfunction

  // updates the calibration bounds and returns the heading for one request
  function automatic heading_t next_heading(logic op, longint x, longint y);
    heading_t h;
    longint xc, yc, sx, sy;
    h = '0;
    if (op == chac_pkg::OP_CLEAR) begin
      x_lo = 0;
      x_hi = 0;
      y_lo = 0;
      y_hi = 0;
      return h;
    end
    if (x < x_lo) x_lo = x;
    if (x > x_hi) x_hi = x;
    if (y < y_lo) y_lo = y;
    if (y > y_hi) y_hi = y;
    if (x_lo == x_hi || y_lo == y_hi) return h;
    xc = x - (x_hi + x_lo) / 2;
    yc = y - (y_hi + y_lo) / 2;
    sx = x_hi - x_lo;
    sy = y_hi - y_lo;
    h.deg = 9'(angle_deg(xc * sy, yc * sx));
    h.ok  = 1'b1;
    return h;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      x_lo = 0;
      x_hi = 0;
      y_lo = 0;
      y_hi = 0;
      heading_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (heading_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, got deg %0d valid %0b",
                   $time, out_mon.heading_deg, out_mon.heading_valid);
        end else begin
          want = heading_q.pop_front();
          if (out_mon.heading_deg !== want.deg) begin
            errs++;
            $display("%0t: heading_deg mismatch: expected %0d, got %0d",
                     $time, want.deg, out_mon.heading_deg);
          end
          if (out_mon.heading_valid !== want.ok) begin
            errs++;
            $display("%0t: heading_valid mismatch: expected %0b, got %0b",
                     $time, want.ok, out_mon.heading_valid);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        heading_q.push_back(next_heading(in_mon.opcode, longint'(in_mon.mag_x),
                                         longint'(in_mon.mag_y)));
      end
    end
    fail_count    <= errs;
    pending_count <= heading_q.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 1825;
  localparam int CALM_FROM    = 1650;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm_tail = 1'b0;
  int   fail_count;
  int   pending_count;

  chac_in_if  in_chan ();
  chac_out_if out_chan ();

  compass_heading_autocal u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  heading_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // returns at the edge where the request was taken
  task automatic send_request(input logic op, input logic [15:0] x, input logic [15:0] y);
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.mag_x  <= x;
    in_chan.mag_y  <= y;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic sample(input int x, input int y);
    send_request(chac_pkg::OP_SAMPLE, 16'(x), 16'(y));
  endtask

  task automatic wait_all_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(0, 6))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hffff;
      3: return 16'h0000;
      4: return 16'h0001;
      5: return 16'h7ffe;
      default: return 16'h7fff;
    endcase
  endfunction

  function automatic logic [15:0] pick_near(input int reach);
    return 16'($signed($urandom_range(0, 2 * reach)) - reach);
  endfunction

  // receiver stalls
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm_tail) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int i, r, reach, gap_pct;
    logic [15:0] x, y;
    in_chan.valid  <= 1'b0;
    in_chan.opcode <= chac_pkg::OP_SAMPLE;
    in_chan.mag_x  <= '0;
    in_chan.mag_y  <= '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero spans right after reset, then both spans open
    sample(0, 0);
    sample(100, 0);
    sample(0, 100);
    send_request(chac_pkg::OP_CLEAR, 16'h8000, 16'h7fff);
    // symmetric bounds of +-100, then the axis and diagonal cases
    sample(-100, -100);
    sample(100, 100);
    sample(0, 0);
    sample(-100, 0);
    sample(100, 0);
    sample(0, 100);
    sample(0, -100);
    sample(100, -100);
    sample(-100, 100);
    in_chan.valid <= 1'b0;
    repeat (3) @(posedge clk);
    sample(-100, -100);
    send_request(chac_pkg::OP_CLEAR, 16'hffff, 16'h0000);
    wait_all_results();
    // full-scale extremes
    sample(32767, 32767);
    sample(-32768, -32768);
    sample(32767, -32768);
    sample(-32768, 32767);
    sample(0, 0);
    sample(-1, 1);
    sample(-32768, 0);
    send_request(chac_pkg::OP_CLEAR, 16'h0000, 16'hffff);
    sample(-1, -1);

    gap_pct = 30;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == CALM_FROM) calm_tail = 1'b1;
      if (i % 64 == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      if (i == 600 || i == 1200) wait_all_results();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_request(chac_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom()));
      end else begin
        if (r < 40) begin
          x = 16'($urandom());
          y = 16'($urandom());
        end else if (r < 75) begin
          reach = $urandom_range(1, 2000);
          x = pick_near(reach);
          y = pick_near(reach);
        end else if (r < 88) begin
          x = pick_edge();
          y = pick_edge();
        end else if (r < 94) begin
          x = 16'h0000;
          y = pick_near($urandom_range(1, 32767));
        end else begin
          x = pick_near($urandom_range(1, 32767));
          y = 16'h0000;
        end
        send_request(chac_pkg::OP_SAMPLE, x, y);
      end
      if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end

    wait_all_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: compass_heading_autocal.f
hw/rtl/chac_pkg.sv
hw/rtl/chac_if.sv
hw/rtl/compass_heading_autocal.sv
test/heading_checker.sv
test/testbench.sv
